// ===== rtl/core/pci_pkg.sv =====
// Shared constants, register codes and word types for the clamped-integrator PID block.
package pci_pkg;

  localparam int ERROR_BITS     = 16;
  localparam int GAIN_FRAC_BITS = 8;

  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 24;
  localparam int DRIVE_W = 25;

  localparam int PROD_W  = ERROR_BITS + GAIN_W;
  localparam int DIFF_W  = ERROR_BITS + 1;
  localparam int DPROD_W = DIFF_W + GAIN_W;
  localparam int ACC_W   = LIMIT_W + GAIN_FRAC_BITS;
  localparam int ISUM_W  = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 1;

  localparam int TERM_W0 = (ACC_W > PROD_W) ? ACC_W : PROD_W;
  localparam int TERM_W  = (TERM_W0 > DPROD_W) ? TERM_W0 : DPROD_W;
  localparam int SUM_W   = (TERM_W + 2 > DRIVE_W) ? TERM_W + 2 : DRIVE_W + 1;

  localparam longint DRIVE_MAX = (64'sd1 <<< (DRIVE_W - 1)) - 64'sd1;
  localparam longint DRIVE_MIN = -(64'sd1 <<< (DRIVE_W - 1));

  localparam int MID_DEPTH = 4;
  localparam int MID_AW    = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH = 2;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  localparam int REG_COUNT = 5;
  localparam int REG_IDX_W = $clog2(REG_COUNT);
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam int PDATA_W   = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_P = REG_IDX_W'(0),
    REG_GAIN_I = REG_IDX_W'(1),
    REG_GAIN_D = REG_IDX_W'(2),
    REG_UPPER  = REG_IDX_W'(3),
    REG_LOWER  = REG_IDX_W'(4)
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]  gain_p;
    logic signed [GAIN_W-1:0]  gain_i;
    logic signed [GAIN_W-1:0]  gain_d;
    logic signed [LIMIT_W-1:0] integral_upper;
    logic signed [LIMIT_W-1:0] integral_lower;
  } cfg_t;

  // One classified word between front and back.
  typedef struct packed {
    logic signed [PROD_W-1:0] p_term;
    logic signed [PROD_W-1:0] i_prod;
    logic signed [DIFF_W-1:0] diff;
    logic                     d_en;
    logic                     restart;
  } mid_entry_t;

endpackage

// ===== rtl/core/pci_front.sv =====
// Front end: accepts error words, forms P and I products and the error difference.
module pci_front (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     push,
  input  logic signed [pci_pkg::ERROR_BITS-1:0]    error_sample,
  input  logic                                     restart,
  input  pci_pkg::cfg_t                            cfg,
  input  logic                                     q_full,
  output logic                                     q_wr,
  output pci_pkg::mid_entry_t                      q_wdata,
  output logic                                     full
);
  import pci_pkg::*;

  logic signed [ERROR_BITS-1:0] prev_error;
  logic                         started;
  logic signed [ERROR_BITS-1:0] prev_eff;
  logic                         accept;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_wr   = accept;

  always_comb begin
    // a restart word sees a cleared history
    prev_eff          = restart ? '0 : prev_error;
    q_wdata.p_term    = $signed(cfg.gain_p) * error_sample;
    q_wdata.i_prod    = $signed(cfg.gain_i) * error_sample;
    q_wdata.diff      = error_sample - prev_eff;
    q_wdata.d_en      = started && !restart;
    q_wdata.restart   = restart;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      started    <= 1'b0;
    end else if (accept) begin
      prev_error <= error_sample;
      started    <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/pci_queue.sv =====
// Short queue of classified words between front and back.
module pci_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  pci_pkg::mid_entry_t wdata,
  input  logic                rd,
  output pci_pkg::mid_entry_t rdata,
  output logic                q_full,
  output logic                q_empty
);
  import pci_pkg::*;

  mid_entry_t          mem [MID_DEPTH];
  logic [MID_AW-1:0]   wr_ptr;
  logic [MID_AW-1:0]   rd_ptr;
  logic [MID_AW:0]     count;

  assign q_full  = (count == (MID_AW + 1)'(MID_DEPTH));
  assign q_empty = (count == '0);
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/pci_back.sv =====
// Back end: clamped integrator, derivative product, drive sum and result queue.
module pci_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pci_pkg::cfg_t                         cfg,
  input  pci_pkg::mid_entry_t                   q_rdata,
  input  logic                                  q_empty,
  output logic                                  q_rd,
  input  logic                                  pop,
  output logic                                  empty,
  output logic signed [pci_pkg::DRIVE_W-1:0]    drive
);
  import pci_pkg::*;

  logic signed [ACC_W-1:0]   integral_acc;
  logic signed [ACC_W-1:0]   acc_base;
  logic signed [ACC_W-1:0]   acc_next;
  logic signed [ISUM_W-1:0]  acc_sum;
  logic signed [ISUM_W-1:0]  acc_clip;
  logic signed [ISUM_W-1:0]  lim_hi;
  logic signed [ISUM_W-1:0]  lim_lo;
  logic signed [DPROD_W-1:0] d_next;

  logic                      s1_valid;
  logic signed [PROD_W-1:0]  s1_p;
  logic signed [ACC_W-1:0]   s1_acc;
  logic signed [DPROD_W-1:0] s1_d;

  logic signed [SUM_W-1:0]   total;
  logic signed [SUM_W-1:0]   shifted;
  logic signed [SUM_W-1:0]   drive_hi;
  logic signed [SUM_W-1:0]   drive_lo;
  logic signed [DRIVE_W-1:0] drive_next;

  logic signed [DRIVE_W-1:0] out_mem [OUT_DEPTH];
  logic [OUT_AW-1:0]         out_wr;
  logic [OUT_AW-1:0]         out_rd;
  logic [OUT_AW:0]           out_cnt;

  logic pop_fire;
  logic o_space;
  logic s1_go;
  logic s1_free;

  assign pop_fire = pop && !empty;
  assign o_space  = (out_cnt != (OUT_AW + 1)'(OUT_DEPTH)) || pop_fire;
  assign s1_go    = s1_valid && o_space;
  assign s1_free  = !s1_valid || s1_go;
  assign q_rd     = !q_empty && s1_free;

  assign empty = (out_cnt == '0);
  assign drive = out_mem[out_rd];

  // integrator update for the word at the queue head
  always_comb begin
    acc_base = q_rdata.restart ? '0 : integral_acc;
    lim_hi   = ISUM_W'($signed(cfg.integral_upper)) <<< GAIN_FRAC_BITS;
    lim_lo   = ISUM_W'($signed(cfg.integral_lower)) <<< GAIN_FRAC_BITS;
    acc_sum  = acc_base + $signed(q_rdata.i_prod);
    acc_clip = acc_sum;
    // upper limit first, then lower: crossed limits settle on the lower one
    if (acc_clip > lim_hi) begin
      acc_clip = lim_hi;
    end
    if (acc_clip < lim_lo) begin
      acc_clip = lim_lo;
    end
    if (cfg.gain_i != '0) begin
      acc_next = ACC_W'(acc_clip);
    end else begin
      acc_next = acc_base;
    end
    if (q_rdata.d_en) begin
      d_next = $signed(cfg.gain_d) * $signed(q_rdata.diff);
    end else begin
      d_next = '0;
    end
  end

  // sum, floor shift, saturate
  always_comb begin
    drive_hi = SUM_W'(DRIVE_MAX);
    drive_lo = SUM_W'(DRIVE_MIN);
    total    = s1_p + s1_acc + s1_d;
    shifted  = total >>> GAIN_FRAC_BITS;
    if (shifted > drive_hi) begin
      drive_next = DRIVE_W'(DRIVE_MAX);
    end else if (shifted < drive_lo) begin
      drive_next = DRIVE_W'(DRIVE_MIN);
    end else begin
      drive_next = DRIVE_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (q_rd) begin
        integral_acc <= acc_next;
        s1_valid     <= 1'b1;
      end else if (s1_go) begin
        s1_valid     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      s1_p   <= $signed(q_rdata.p_term);
      s1_acc <= acc_next;
      s1_d   <= d_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_mem[out_wr] <= drive_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr  <= '0;
      out_rd  <= '0;
      out_cnt <= '0;
    end else begin
      if (s1_go) begin
        out_wr <= out_wr + 1'b1;
      end
      if (pop_fire) begin
        out_rd <= out_rd + 1'b1;
      end
      if (s1_go && !pop_fire) begin
        out_cnt <= out_cnt + 1'b1;
      end else if (pop_fire && !s1_go) begin
        out_cnt <= out_cnt - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/pid_clamped_integrator.sv =====
// Top level of the clamped-integrator PID block: register file and front/queue/back wiring.
//
//   channel   handshake               payload
//   --------  ----------------------  -----------------------------
//   input     push / full             error_sample, restart
//   result    pop / empty             drive
//   config    psel penable pwrite     paddr, pwdata, prdata, pready
//
// One word is accepted every clock while full is low; the only loop is the integrator
// add-and-clamp in the back end, which closes through the integrator register alone.
// On its way to the result ports a word passes the queue, the back-end stage register and the result queue.
// A four-word queue parts front from back, and a two-word result queue parts
// the back from the consumer, so either side may stall without stopping the other.
// Synchronous reset clears control state, the integrator and the derivative history.
module pid_clamped_integrator (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    push,
  output logic                                    full,
  input  logic signed [pci_pkg::ERROR_BITS-1:0]   error_sample,
  input  logic                                    restart,
  output logic                                    empty,
  input  logic                                    pop,
  output logic signed [pci_pkg::DRIVE_W-1:0]      drive,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [pci_pkg::PADDR_W-1:0]             paddr,
  input  logic [pci_pkg::PDATA_W-1:0]             pwdata,
  output logic [pci_pkg::PDATA_W-1:0]             prdata,
  output logic                                    pready
);
  import pci_pkg::*;

  cfg_t       cfg;
  logic       cfg_wr;
  reg_idx_t   reg_idx;
  logic       q_wr;
  logic       q_rd;
  logic       q_full;
  logic       q_empty;
  mid_entry_t q_wdata;
  mid_entry_t q_rdata;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p         <= GAIN_W'(256);
      cfg.gain_i         <= GAIN_W'(2560);
      cfg.gain_d         <= '0;
      cfg.integral_upper <= LIMIT_W'(65535);
      cfg.integral_lower <= LIMIT_W'(-65535);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GAIN_P: cfg.gain_p         <= pwdata[GAIN_W-1:0];
        REG_GAIN_I: cfg.gain_i         <= pwdata[GAIN_W-1:0];
        REG_GAIN_D: cfg.gain_d         <= pwdata[GAIN_W-1:0];
        REG_UPPER:  cfg.integral_upper <= pwdata[LIMIT_W-1:0];
        REG_LOWER:  cfg.integral_lower <= pwdata[LIMIT_W-1:0];
        default: begin
          // drop writes past the register list
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN_P: prdata = PDATA_W'($signed(cfg.gain_p));
      REG_GAIN_I: prdata = PDATA_W'($signed(cfg.gain_i));
      REG_GAIN_D: prdata = PDATA_W'($signed(cfg.gain_d));
      REG_UPPER:  prdata = PDATA_W'($signed(cfg.integral_upper));
      REG_LOWER:  prdata = PDATA_W'($signed(cfg.integral_lower));
      default:    prdata = '0;
    endcase
  end

  pci_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .error_sample (error_sample),
    .restart      (restart),
    .cfg          (cfg),
    .q_full       (q_full),
    .q_wr         (q_wr),
    .q_wdata      (q_wdata),
    .full         (full)
  );

  pci_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wdata   (q_wdata),
    .rd      (q_rd),
    .rdata   (q_rdata),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  pci_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_rdata (q_rdata),
    .q_empty (q_empty),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .drive   (drive)
  );

endmodule

// ===== rtl/core/pci_checker.sv =====
// Port-level checks of the clamped-integrator PID block, bound to the top level.
module pci_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  push,
  input logic                                  full,
  input logic                                  empty,
  input logic                                  pop,
  input logic signed [pci_pkg::DRIVE_W-1:0]    drive
);
  import pci_pkg::*;

  // words accepted and not yet taken: queue, one stage, result queue
  logic [3:0] in_flight;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + 4'((push && !full) ? 1 : 0) - 4'((pop && !empty) ? 1 : 0);
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("block not idle after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    !empty |-> in_flight != 4'd0)
    else $error("result shown with no word in flight");

  a_full_backlog: assert property (@(posedge clk) disable iff (rst)
    full |-> in_flight >= 4'(MID_DEPTH))
    else $error("full raised with front queue not filled");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(drive))
    else $error("stalled result changed");

endmodule

bind pid_clamped_integrator pci_checker u_pci_checker (.*);
